FILE: src/aiw_pkg.sv
// ============================================================================
// aiw_pkg
// Shared types and constants for the nearest-neighbor affine image warp.
// ============================================================================
`default_nettype none

package aiw_pkg;

  // Frame store geometry.
  localparam int MAX_DIM     = 256;
  localparam int DIM_BITS    = $clog2(MAX_DIM);
  localparam int ADDR_BITS   = 2 * DIM_BITS;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int PIXEL_BITS  = 16;

  // Fixed field widths of the interface.
  localparam int COORD_BITS = 8;
  localparam int PIX_IO_BITS = 16;
  localparam int COEF_BITS  = 32;
  localparam int SIZE_BITS  = 9;
  localparam int CFG_IDX_BITS = 3;

  // Datapath widths: coefficient times a zero-extended coordinate, and the sum.
  localparam int PROD_BITS = COEF_BITS + COORD_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = SUM_BITS - FRAC_BITS;
  localparam logic [SUM_BITS-1:0] HALF_Q16 = SUM_BITS'(1) << (FRAC_BITS - 1);

  // Output queue.
  localparam int OUTQ_DEPTH    = 8;
  localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } aiw_cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COEF_A = 3'd0,
    REG_COEF_B = 3'd1,
    REG_COEF_C = 3'd2,
    REG_COEF_D = 3'd3,
    REG_COEF_E = 3'd4,
    REG_COEF_F = 3'd5,
    REG_WIDTH  = 3'd6,
    REG_HEIGHT = 3'd7
  } aiw_reg_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] a;
    logic signed [COEF_BITS-1:0] b;
    logic signed [COEF_BITS-1:0] c;
    logic signed [COEF_BITS-1:0] d;
    logic signed [COEF_BITS-1:0] e;
    logic signed [COEF_BITS-1:0] f;
    logic [SIZE_BITS-1:0]        width;
    logic [SIZE_BITS-1:0]        height;
  } aiw_cfg_t;

  // One frame store access as issued by the mapping pipeline.
  typedef struct packed {
    logic                  valid;
    logic                  wr;
    logic                  outside;
    logic [ADDR_BITS-1:0]  addr;
    logic [PIXEL_BITS-1:0] wdata;
  } aiw_mem_req_t;

endpackage

`default_nettype wire

FILE: src/aiw_ram.sv
// ============================================================================
// aiw_ram
// Generic single-port synchronous RAM with a registered read.
// ============================================================================
`default_nettype none

module aiw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: src/aiw_map.sv
// ============================================================================
// aiw_map
// Three-stage coordinate mapping pipeline: capture, multiply, sum. The last
// stage rounds, checks the source bounds and issues the frame store access.
// ============================================================================
`default_nettype none

module aiw_map (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_fire,
  input  wire logic                              command,
  input  wire logic [aiw_pkg::COORD_BITS-1:0]    coord_x,
  input  wire logic [aiw_pkg::COORD_BITS-1:0]    coord_y,
  input  wire logic [aiw_pkg::PIX_IO_BITS-1:0]   pixel_in,
  input  wire aiw_pkg::aiw_cfg_t                 cfg,
  output aiw_pkg::aiw_mem_req_t                  req
);
  import aiw_pkg::*;

  // Stage 1: captured request.
  logic                  s1_valid;
  logic                  s1_fetch;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;
  logic [PIXEL_BITS-1:0] s1_pix;

  // Stage 2: products.
  logic                        s2_valid;
  logic                        s2_fetch;
  logic [COORD_BITS-1:0]       s2_x;
  logic [COORD_BITS-1:0]       s2_y;
  logic [PIXEL_BITS-1:0]       s2_pix;
  logic signed [PROD_BITS-1:0] s2_ax;
  logic signed [PROD_BITS-1:0] s2_by;
  logic signed [PROD_BITS-1:0] s2_dx;
  logic signed [PROD_BITS-1:0] s2_ey;

  // Stage 3: rounded sums.
  logic                  s3_valid;
  logic                  s3_fetch;
  logic [COORD_BITS-1:0] s3_x;
  logic [COORD_BITS-1:0] s3_y;
  logic [PIXEL_BITS-1:0] s3_pix;
  logic [SUM_BITS-1:0]   s3_vx;
  logic [SUM_BITS-1:0]   s3_vy;

  logic signed [COORD_BITS:0] s1_xs;
  logic signed [COORD_BITS:0] s1_ys;
  logic [SUM_BITS-1:0]        vx;
  logic [SUM_BITS-1:0]        vy;
  logic [INT_BITS-1:0]        xp;
  logic [INT_BITS-1:0]        yp;
  logic [SIZE_BITS-1:0]       w_bound;
  logic [SIZE_BITS-1:0]       h_bound;
  logic                       in_image;

  assign s1_xs = $signed({1'b0, s1_x});
  assign s1_ys = $signed({1'b0, s1_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    s1_fetch <= (command == CMD_FETCH);
    s1_x     <= coord_x;
    s1_y     <= coord_y;
    s1_pix   <= PIXEL_BITS'(pixel_in);

    s2_fetch <= s1_fetch;
    s2_x     <= s1_x;
    s2_y     <= s1_y;
    s2_pix   <= s1_pix;
    s2_ax    <= cfg.a * s1_xs;
    s2_by    <= cfg.b * s1_ys;
    s2_dx    <= cfg.d * s1_xs;
    s2_ey    <= cfg.e * s1_ys;

    s3_fetch <= s2_fetch;
    s3_x     <= s2_x;
    s3_y     <= s2_y;
    s3_pix   <= s2_pix;
    s3_vx    <= vx;
    s3_vy    <= vy;
  end

  // The half pixel is folded into the sum, so rounding is a plain floor below.
  assign vx = {s2_ax[PROD_BITS-1], s2_ax} + {s2_by[PROD_BITS-1], s2_by}
            + {{(SUM_BITS-COEF_BITS){cfg.c[COEF_BITS-1]}}, cfg.c} + HALF_Q16;
  assign vy = {s2_dx[PROD_BITS-1], s2_dx} + {s2_ey[PROD_BITS-1], s2_ey}
            + {{(SUM_BITS-COEF_BITS){cfg.f[COEF_BITS-1]}}, cfg.f} + HALF_Q16;

  assign xp = s3_vx[SUM_BITS-1:FRAC_BITS];
  assign yp = s3_vy[SUM_BITS-1:FRAC_BITS];

  assign w_bound = (cfg.width  > SIZE_BITS'(MAX_DIM)) ? SIZE_BITS'(MAX_DIM) : cfg.width;
  assign h_bound = (cfg.height > SIZE_BITS'(MAX_DIM)) ? SIZE_BITS'(MAX_DIM) : cfg.height;

  assign in_image = !xp[INT_BITS-1] && !yp[INT_BITS-1]
                 && (xp < INT_BITS'(w_bound)) && (yp < INT_BITS'(h_bound));

  always_comb begin
    req.valid   = s3_valid;
    req.wr      = s3_valid && !s3_fetch;
    req.outside = !in_image;
    req.wdata   = s3_pix;
    if (s3_fetch) begin
      req.addr = {yp[DIM_BITS-1:0], xp[DIM_BITS-1:0]};
    end else begin
      req.addr = {DIM_BITS'(s3_y), DIM_BITS'(s3_x)};
    end
  end

`ifndef NO_ASSERTIONS
  // Items move down the pipeline one stage per cycle without gaps or copies.
  a_s3_follows_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> ##1 s3_valid)
    else $error("mapping pipeline lost an item");
  a_write_only_loads: assert property (@(posedge clk) disable iff (rst)
    req.wr |-> req.valid && !s3_fetch)
    else $error("frame store written by a fetch");
`endif

endmodule

`default_nettype wire

FILE: src/aiw_outq.sv
// ============================================================================
// aiw_outq
// Small result queue that decouples the pipeline from the receiver.
// ============================================================================
`default_nettype none

module aiw_outq (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  input  wire logic [aiw_pkg::PIX_IO_BITS-1:0] push_pixel,
  input  wire logic                            push_outside,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [aiw_pkg::PIX_IO_BITS-1:0] pixel_out,
  output logic                                 outside
);
  import aiw_pkg::*;

  logic [PIX_IO_BITS-1:0]   q_pixel   [OUTQ_DEPTH];
  logic                     q_outside [OUTQ_DEPTH];
  logic [OUTQ_PTR_BITS-1:0] head;
  logic [OUTQ_PTR_BITS-1:0] tail;
  logic [OUTQ_CNT_BITS-1:0] count;
  logic                     pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign pixel_out = q_pixel[head];
  assign outside   = q_outside[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == OUTQ_PTR_BITS'(OUTQ_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == OUTQ_PTR_BITS'(OUTQ_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count <= count + OUTQ_CNT_BITS'(push) - OUTQ_CNT_BITS'(pop);
    end
    if (push) begin
      q_pixel[tail]   <= push_pixel;
      q_outside[tail] <= push_outside;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != OUTQ_CNT_BITS'(OUTQ_DEPTH)) || pop)
    else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

FILE: src/affine_image_warp_nearest.sv
// ============================================================================
// affine_image_warp_nearest
// Nearest-neighbor affine warp with a 256 x 256 frame store.
// ============================================================================
// Usage: requests enter on the in_ channel (valid/ready). A load request
// writes pixel_in into the frame store at (coord_x, coord_y) and yields no
// result. A fetch request maps (coord_x, coord_y) through the configured
// Q16.16 transform, rounds half up and returns the stored source pixel on
// the out_ channel, or zero with outside set when the mapped point is off
// the image. Results come back in request order.
// Registers are written on the cfg_ channel, which is always ready; they may
// change only while no request is in flight.
// Fetches pass the mapping pipeline, the store read and the queue to out_.
// Throughput: one request per cycle while in_ready is high; each request
// makes exactly one frame store access, issued from the last stage of the
// mapping pipeline. When the receiver stalls, results collect in an 8-entry
// queue; in_ready drops once 8 fetch results are owed.
// Reset clears the pipeline and the queue and restores the identity
// transform with a 256 x 256 image; the frame store content is undefined.
// ============================================================================
`default_nettype none

module affine_image_warp_nearest (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                command,
  input  wire logic [aiw_pkg::COORD_BITS-1:0]      coord_x,
  input  wire logic [aiw_pkg::COORD_BITS-1:0]      coord_y,
  input  wire logic [aiw_pkg::PIX_IO_BITS-1:0]     pixel_in,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [aiw_pkg::PIX_IO_BITS-1:0]     pixel_out,
  output logic                                     outside,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [aiw_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [aiw_pkg::COEF_BITS-1:0]       cfg_data
);
  import aiw_pkg::*;

  aiw_cfg_t               cfg;
  aiw_mem_req_t           req;
  logic                   in_fire;
  logic                   out_fire;
  logic                   fetch_fire;
  logic [OUTQ_CNT_BITS-1:0] pending;
  logic [PIXEL_BITS-1:0]  rdata;
  logic                   rd_valid;
  logic                   rd_outside;
  logic [PIX_IO_BITS-1:0] rd_pixel;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (pending < OUTQ_CNT_BITS'(OUTQ_DEPTH));
  assign in_fire    = in_valid && in_ready;
  assign fetch_fire = in_fire && (command == CMD_FETCH);
  assign out_fire   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a      <= COEF_BITS'(65536);
      cfg.b      <= '0;
      cfg.c      <= '0;
      cfg.d      <= '0;
      cfg.e      <= COEF_BITS'(65536);
      cfg.f      <= '0;
      cfg.width  <= SIZE_BITS'(256);
      cfg.height <= SIZE_BITS'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (aiw_reg_t'(cfg_index))
        REG_COEF_A: cfg.a      <= cfg_data;
        REG_COEF_B: cfg.b      <= cfg_data;
        REG_COEF_C: cfg.c      <= cfg_data;
        REG_COEF_D: cfg.d      <= cfg_data;
        REG_COEF_E: cfg.e      <= cfg_data;
        REG_COEF_F: cfg.f      <= cfg_data;
        REG_WIDTH:  cfg.width  <= cfg_data[SIZE_BITS-1:0];
        REG_HEIGHT: cfg.height <= cfg_data[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Every fetch reserves a queue slot when accepted, so the pipeline never stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + OUTQ_CNT_BITS'(fetch_fire) - OUTQ_CNT_BITS'(out_fire);
    end
  end

  aiw_map u_map (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .command  (command),
    .coord_x  (coord_x),
    .coord_y  (coord_y),
    .pixel_in (pixel_in),
    .cfg      (cfg),
    .req      (req)
  );

  // Loads and fetches reach the store in request order from one stage, so a
  // fetch always sees every earlier load without forwarding.
  aiw_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (req.wr),
    .addr  (req.addr),
    .wdata (req.wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= req.valid && !req.wr;
    end
    rd_outside <= req.outside;
  end

  assign rd_pixel = rd_outside ? '0 : PIX_IO_BITS'(rdata);

  aiw_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (rd_valid),
    .push_pixel   (rd_pixel),
    .push_outside (rd_outside),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_out    (pixel_out),
    .outside      (outside)
  );

`ifndef NO_ASSERTIONS
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= OUTQ_CNT_BITS'(OUTQ_DEPTH))
    else $error("more fetch results owed than queue slots");
  a_result_owed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("result presented that no fetch requested");
  a_load_no_credit: assert property (@(posedge clk) disable iff (rst)
    (in_fire && command == CMD_LOAD && !out_fire) |=> pending == $past(pending))
    else $error("load request changed the result count");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_affine_image_warp_nearest.sv
// ----------------------------------------------------------------------------
// Affine image warp regression
// Loads source pixels and fetches warped destination pixels. A tracker class
// mirrors the frame store and the transform registers and checks every
// fetch result, in order, against its own mapping of the destination point.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_affine_image_warp_nearest;
  import aiw_pkg::*;

  localparam int     CLK_PERIOD   = 10;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     IDLE_PCT     = 18;
  localparam int     DRAIN_CYCLES = 12;
  localparam int     HOLD_CYCLES  = 80;
  localparam int     PHASE_ITEMS  = 85;
  localparam longint ROUND_HALF   = 64'sd32768;

  typedef struct packed {
    logic [PIX_IO_BITS-1:0] pixel;
    logic                   outside;
  } warp_result_t;

  class warp_tracker;
    aiw_cfg_t             regs;
    bit [PIXEL_BITS-1:0]  frame [STORE_DEPTH];
    bit                   loaded [STORE_DEPTH];
    warp_result_t         owed_pixels [$];
    int                   mismatches;

    function void clear();
      regs.a      = 32'sd65536;
      regs.b      = '0;
      regs.c      = '0;
      regs.d      = '0;
      regs.e      = 32'sd65536;
      regs.f      = '0;
      regs.width  = SIZE_BITS'(MAX_DIM);
      regs.height = SIZE_BITS'(MAX_DIM);
      mismatches  = 0;
    endfunction

    function void write_reg(aiw_reg_t idx, logic [COEF_BITS-1:0] data);
      case (idx)
        REG_COEF_A: regs.a = data;
        REG_COEF_B: regs.b = data;
        REG_COEF_C: regs.c = data;
        REG_COEF_D: regs.d = data;
        REG_COEF_E: regs.e = data;
        REG_COEF_F: regs.f = data;
        REG_WIDTH:  regs.width = data[SIZE_BITS-1:0];
        REG_HEIGHT: regs.height = data[SIZE_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Maps a destination point to its source pixel; returns 1 when inside.
    function bit map_point(input logic [COORD_BITS-1:0] x, y,
                           output logic [COORD_BITS-1:0] sx, sy);
      longint vx, vy, xp, yp, w, h;
      vx = longint'($signed(regs.a)) * longint'(x) + longint'($signed(regs.b)) * longint'(y)
           + longint'($signed(regs.c)) + ROUND_HALF;
      vy = longint'($signed(regs.d)) * longint'(x) + longint'($signed(regs.e)) * longint'(y)
           + longint'($signed(regs.f)) + ROUND_HALF;
      xp = vx >>> FRAC_BITS;
      yp = vy >>> FRAC_BITS;
      w = regs.width;
      h = regs.height;
      if (w > MAX_DIM) w = MAX_DIM;
      if (h > MAX_DIM) h = MAX_DIM;
      sx = xp[COORD_BITS-1:0];
      sy = yp[COORD_BITS-1:0];
      return (xp >= 0 && yp >= 0 && xp < w && yp < h);
    endfunction

    // True when a fetch of (x, y) would read a pixel that was never loaded.
    function bit needs_preload(input logic [COORD_BITS-1:0] x, y,
                               output logic [COORD_BITS-1:0] sx, sy);
      return map_point(x, y, sx, sy) && !loaded[{sy, sx}];
    endfunction

    function void note_request(aiw_cmd_t cmd, logic [COORD_BITS-1:0] x, y,
                               logic [PIX_IO_BITS-1:0] pix);
      logic [COORD_BITS-1:0] sx, sy;
      warp_result_t res;
      if (cmd == CMD_LOAD) begin
        frame[{y, x}]  = pix;
        loaded[{y, x}] = 1'b1;
      end else begin
        if (map_point(x, y, sx, sy)) begin
          res.pixel   = frame[{sy, sx}];
          res.outside = 1'b0;
        end else begin
          res.pixel   = '0;
          res.outside = 1'b1;
        end
        owed_pixels.push_back(res);
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 200) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(logic [PIX_IO_BITS-1:0] pix, logic outside_flag);
      warp_result_t want;
      if (owed_pixels.size() == 0) begin
        report($sformatf("result with no fetch pending: pixel %h outside %b",
                         pix, outside_flag));
      end else begin
        want = owed_pixels.pop_front();
        if (pix !== want.pixel)
          report($sformatf("pixel_out %h, predicted %h", pix, want.pixel));
        if (outside_flag !== want.outside)
          report($sformatf("outside %b, predicted %b", outside_flag, want.outside));
      end
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     command;
  logic [COORD_BITS-1:0]    coord_x;
  logic [COORD_BITS-1:0]    coord_y;
  logic [PIX_IO_BITS-1:0]   pixel_in;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [PIX_IO_BITS-1:0]   pixel_out;
  logic                     outside;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [COEF_BITS-1:0]     cfg_data;

  warp_tracker sb;
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;
  int          hold_left = 0;
  int          cycles = 0;

  affine_image_warp_nearest u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .outside   (outside),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("affine_image_warp_nearest regression: fail");
      $finish;
    end
  end

  // Result side: check every accepted result, stall at random, and hold off
  // for a long stretch when asked so that the result queue fills up.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(pixel_out, outside);
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Returns at the edge that accepted the request with in_valid still high;
  // the caller either offers the next request or lowers valid in that step.
  task automatic send_request(input aiw_cmd_t cmd, input logic [COORD_BITS-1:0] x, y,
                              input logic [PIX_IO_BITS-1:0] pix);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    coord_x  <= x;
    coord_y  <= y;
    pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, x, y, pix);
  endtask

  // A fetch whose source pixel was never loaded gets that pixel loaded first.
  task automatic fetch_pixel(input logic [COORD_BITS-1:0] x, y);
    logic [COORD_BITS-1:0] sx, sy;
    if (sb.needs_preload(x, y, sx, sy))
      send_request(CMD_LOAD, sx, sy, PIX_IO_BITS'($urandom));
    send_request(CMD_FETCH, x, y, PIX_IO_BITS'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.owed_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [COEF_BITS-1:0] a, b, c, d, e, f, w, h);
    logic [COEF_BITS-1:0] vals [8];
    aiw_reg_t idx;
    vals = '{a, b, c, d, e, f, w, h};
    wait_idle();
    idx = idx.first();
    for (int i = 0; i < idx.num(); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx, vals[i]);
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
  endtask

  // Mixes loads, mostly inside the image, with fetches over the given
  // destination span; a quarter of the fetches run along the diagonal.
  task automatic run_random(input int count, input int x_span, input int y_span);
    logic [COORD_BITS-1:0] x, y;
    int lw, lh;
    lw = sb.regs.width;
    lh = sb.regs.height;
    if (lw == 0 || lw > MAX_DIM) lw = MAX_DIM;
    if (lh == 0 || lh > MAX_DIM) lh = MAX_DIM;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 35) begin
        if ($urandom_range(99) < 80) begin
          x = COORD_BITS'($urandom_range(lw - 1));
          y = COORD_BITS'($urandom_range(lh - 1));
        end else begin
          x = COORD_BITS'($urandom);
          y = COORD_BITS'($urandom);
        end
        send_request(CMD_LOAD, x, y, PIX_IO_BITS'($urandom));
      end else begin
        x = COORD_BITS'($urandom_range(x_span - 1));
        y = ($urandom_range(3) == 0) ? x : COORD_BITS'($urandom_range(y_span - 1));
        fetch_pixel(x, y);
      end
    end
  endtask

  initial begin
    int rw, rh;
    sb = new();
    sb.clear();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    command   <= CMD_LOAD;
    coord_x   <= '0;
    coord_y   <= '0;
    pixel_in  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_COEF_A;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identity transform after reset: corners and pixel extremes.
    send_request(CMD_LOAD, 8'd0, 8'd0, 16'hFFFF);
    send_request(CMD_LOAD, 8'd255, 8'd255, 16'h0000);
    send_request(CMD_LOAD, 8'd255, 8'd0, 16'hA5A5);
    send_request(CMD_LOAD, 8'd0, 8'd255, 16'h5A5A);
    fetch_pixel(8'd0, 8'd0);
    fetch_pixel(8'd255, 8'd255);
    fetch_pixel(8'd255, 8'd0);
    fetch_pixel(8'd0, 8'd255);

    // Offsets just past minus one half and just below one half; a destination column past
    // the image width is still mapped.
    apply_setting(32'h0001_0000, 32'h0, 32'hFFFF_7FFF, 32'h0, 32'h0001_0000,
                  32'h0000_7FFF, 32'd255, 32'd256);
    fetch_pixel(8'd0, 8'd0);
    fetch_pixel(8'd1, 8'd0);
    fetch_pixel(8'd255, 8'd0);
    fetch_pixel(8'd255, 8'd255);
    fetch_pixel(8'd128, 8'd200);

    // Zero width puts every fetch outside.
    apply_setting(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'd0, 32'h1FF);
    fetch_pixel(8'd0, 8'd0);
    fetch_pixel(8'd200, 8'd100);

    // Identity over the full image, with a long receiver stall.
    apply_setting(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'd256, 32'd256);
    run_random(30, 256, 256);
    hold_request = 1'b1;
    run_random(PHASE_ITEMS - 30, 256, 256);

    // Small image shifted by half pixels.
    apply_setting(32'h0001_0000, 32'h0, 32'h0003_8000, 32'h0, 32'h0001_0000,
                  32'hFFFD_8000, 32'd16, 32'd8);
    run_random(PHASE_ITEMS, 24, 16);

    // Half scale with no idling on either side.
    apply_setting(32'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h0000_8000, 32'h0, 32'd64, 32'd64);
    quiet = 1'b1;
    run_random(PHASE_ITEMS, 140, 140);
    quiet = 1'b0;

    // Rotation by about thirty degrees with a translation.
    apply_setting(32'd56756, 32'hFFFF_8000, 32'h000A_0000, 32'h0000_8000, 32'd56756,
                  32'hFFFB_0000, 32'd40, 32'd40);
    run_random(PHASE_ITEMS, 48, 48);

    // Extreme gains: the diagonal folds onto the origin; oversized width saturates.
    apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h0, 32'h1FF, 32'd256);
    run_random(PHASE_ITEMS, 256, 256);

    // One-pixel image, every point mapped onto it from both sides of the half.
    apply_setting(32'h0, 32'h0, 32'h0000_7FFF, 32'h0, 32'h0, 32'hFFFF_8000, 32'd1, 32'd1);
    run_random(PHASE_ITEMS, 256, 256);

    // Horizontal mirror; the width write carries set upper bits.
    apply_setting(32'hFFFF_0000, 32'h0, 32'h00FF_0000, 32'h0, 32'h0001_0000, 32'h0,
                  32'hFFFF_FF2C, 32'd200);
    run_random(PHASE_ITEMS, 256, 256);

    // Random moderate transform and random size.
    rw = $urandom_range(1, MAX_DIM);
    rh = $urandom_range(1, MAX_DIM);
    apply_setting(32'($urandom_range(262144)) - 32'd131072,
                  32'($urandom_range(131072)) - 32'd65536,
                  32'($urandom_range(8388608)) - 32'd4194304,
                  32'($urandom_range(131072)) - 32'd65536,
                  32'($urandom_range(262144)) - 32'd131072,
                  32'($urandom_range(8388608)) - 32'd4194304,
                  32'(rw), 32'(rh));
    run_random(PHASE_ITEMS, (rw + 8 > MAX_DIM) ? MAX_DIM : rw + 8,
               (rh + 8 > MAX_DIM) ? MAX_DIM : rh + 8);

    wait_idle();
    if (sb.mismatches == 0) begin
      $display("affine_image_warp_nearest regression: pass");
    end else begin
      $display("affine_image_warp_nearest regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
src/aiw_pkg.sv
src/aiw_ram.sv
src/aiw_map.sv
src/aiw_outq.sv
src/affine_image_warp_nearest.sv
tb/tb_affine_image_warp_nearest.sv
